### sv/sorpcs_pkg.sv
`timescale 1ns / 1ps

package sorpcs_pkg;

   localparam int COORD_FRAC_BITS = 16;

   // term scale: magnitude = |q| * |s| * 2^(F-14) / R
   localparam int FRAC_EXP  = COORD_FRAC_BITS - 14;
   localparam int EXP_POS   = (FRAC_EXP > 0) ? FRAC_EXP : 0;
   localparam int EXP_NEG   = (FRAC_EXP < 0) ? -FRAC_EXP : 0;
   localparam int DIV_W     = 33 + EXP_NEG;
   localparam int DIV_STEPS = 63 + EXP_POS;
   localparam int SQRT_STEPS = 32;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int PHASE_SH  = 48 + COORD_FRAC_BITS;

   localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
   localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
   localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
   localparam logic [63:0] SIGN64         = 64'h8000_0000_0000_0000;
   localparam logic [23:0] WAVE_RESET     = 24'd65536;

   // Taylor divisors n*(n+1) for n = 14, 12, ..., 2
   localparam logic [2:0] TAYLOR_LAST = 3'd6;
   localparam logic [31:0] RECIP_210 = 32'((64'd1 << 32) / 64'd210);
   localparam logic [31:0] RECIP_156 = 32'((64'd1 << 32) / 64'd156);
   localparam logic [31:0] RECIP_110 = 32'((64'd1 << 32) / 64'd110);
   localparam logic [31:0] RECIP_72  = 32'((64'd1 << 32) / 64'd72);
   localparam logic [31:0] RECIP_42  = 32'((64'd1 << 32) / 64'd42);
   localparam logic [31:0] RECIP_20  = 32'((64'd1 << 32) / 64'd20);
   localparam logic [31:0] RECIP_6   = 32'((64'd1 << 32) / 64'd6);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SQRT,
      ST_PH0, ST_PH1, ST_PH2, ST_PH3, ST_PH4,
      ST_FOLD, ST_Y, ST_Y2, ST_TA, ST_TB, ST_TC, ST_TD,
      ST_SIN, ST_NUM, ST_DIV, ST_TERM, ST_ACC
   } state_type;

   function automatic logic [7:0] taylor_div(input logic [2:0] idx);
      case (idx)
         3'd0:    return 8'd210;
         3'd1:    return 8'd156;
         3'd2:    return 8'd110;
         3'd3:    return 8'd72;
         3'd4:    return 8'd42;
         3'd5:    return 8'd20;
         default: return 8'd6;
      endcase
   endfunction

   function automatic logic [31:0] taylor_recip(input logic [2:0] idx);
      case (idx)
         3'd0:    return RECIP_210;
         3'd1:    return RECIP_156;
         3'd2:    return RECIP_110;
         3'd3:    return RECIP_72;
         3'd4:    return RECIP_42;
         3'd5:    return RECIP_20;
         default: return RECIP_6;
      endcase
   endfunction

endpackage

### sv/sin_over_r_point_cluster_sum.sv
`timescale 1ns / 1ps

// Sin-over-r potential accumulator. Each req beat pairs a target point with a
// source point and its charge; the block adds charge * sin(k*r) / r into a
// saturating Q32.32 running sum, and on the beat marked last_source it sends
// the sum (and whether anything clipped) as one rsp beat, then starts over.
// All products share one 32x32 multiplier under a small sequencer, so
// req_ready is high only while the sequencer is idle; a new beat is not
// taken until the last one is through. A beat with distinct points runs
// the squares, a bit-pair square root, the phase product, seven Taylor steps
// of the sine, the restoring divide by r and the final add. Coincident
// points add nothing and go straight to the final add. A finished sum waits
// in the rsp register while the next beats are taken; only the next
// last_source beat holds if that register is still full. wave_number is
// written through the csr port, which is always ready; write it only while
// the block is idle.
module sin_over_r_point_cluster_sum (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_wave_number,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_source_x,
   input  logic signed [31:0] req_source_y,
   input  logic signed [31:0] req_source_z,
   input  logic signed [31:0] req_source_charge,
   input  logic               req_last_source,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_potential_sum,
   output logic               rsp_saturated
);
   import sorpcs_pkg::*;

   state_type state_ff, state_in;

   // control
   logic [23:0]      wave_ff, wave_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       n_ff, n_in;
   logic             last_ff, last_in;
   logic             zero_ff, zero_in;
   logic [63:0]      sum_ff, sum_in;
   logic             clip_ff, clip_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [31:0]      hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;
   logic [31:0]      cmag_ff, cmag_in;
   logic             chgneg_ff, chgneg_in;
   logic [127:0]     acc_ff, acc_in;
   logic [63:0]      rem_ff, rem_in;
   logic [63:0]      quo_ff, quo_in;
   logic [32:0]      r_ff, r_in;
   logic [56:0]      p_ff, p_in;
   logic [30:0]      f_ff, f_in;
   logic             sneg_ff, sneg_in;
   logic [30:0]      y_ff, y_in;
   logic [31:0]      y2_ff, y2_in;
   logic [30:0]      t_ff, t_in;
   logic [31:0]      x_ff, x_in;
   logic [31:0]      q0_ff, q0_in;
   logic [31:0]      qd_ff, qd_in;
   logic [30:0]      smag_ff, smag_in;
   logic [62:0]      dvd_ff, dvd_in;
   logic             over_ff, over_in;
   logic [63:0]      term_ff, term_in;
   logic [63:0]      rsp_sum_ff, rsp_sum_in;
   logic             rsp_sat_ff, rsp_sat_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   logic req_fire, out_free;

   // input-side helpers
   logic signed [32:0] dx, dy, dz;
   logic [32:0]        ax, ay, az;
   logic [33:0]        rx, ry, rz;

   // step helpers
   logic [63:0]      sq_bit, sq_sum;
   logic             sq_ge;
   logic [31:0]      phase;
   logic [DIV_W-1:0] div_w;
   logic [DIV_W:0]   div_r2;
   logic             div_ge;
   logic [31:0]      td_rem, td_q, td_d;
   logic [63:0]      lim, qc, add_term, add_sum;
   logic             term_clip, add_ovf;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign prod      = mul_a * mul_b;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_potential_sum = rsp_sum_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire) state_in = (zero_in) ? ST_ACC : ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SQZ;
         ST_SQZ:   state_in = ST_SQRT;
         ST_SQRT:  if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = ST_PH0;
         ST_PH0:   state_in = ST_PH1;
         ST_PH1:   state_in = ST_PH2;
         ST_PH2:   state_in = ST_PH3;
         ST_PH3:   state_in = ST_PH4;
         ST_PH4:   state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_Y;
         ST_Y:     state_in = ST_Y2;
         ST_Y2:    state_in = ST_TA;
         ST_TA:    state_in = ST_TB;
         ST_TB:    state_in = ST_TC;
         ST_TC:    state_in = ST_TD;
         ST_TD:    state_in = (n_ff == TAYLOR_LAST) ? ST_SIN : ST_TA;
         ST_SIN:   state_in = ST_NUM;
         ST_NUM:   state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_TERM;
         ST_TERM:  state_in = ST_ACC;
         ST_ACC:   if (!last_ff || out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operand select
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SQX:  begin mul_a = hx_ff; mul_b = hx_ff; end
         ST_SQY:  begin mul_a = hy_ff; mul_b = hy_ff; end
         ST_SQZ:  begin mul_a = hz_ff; mul_b = hz_ff; end
         ST_PH0:  begin mul_a = {8'd0, wave_ff}; mul_b = quo_ff[31:0]; end
         ST_PH1:  begin mul_a = p_ff[31:0]; mul_b = INV_TWO_PI_Q64[31:0]; end
         ST_PH2:  begin mul_a = p_ff[31:0]; mul_b = INV_TWO_PI_Q64[63:32]; end
         ST_PH3:  begin mul_a = {7'd0, p_ff[56:32]}; mul_b = INV_TWO_PI_Q64[31:0]; end
         ST_PH4:  begin mul_a = {7'd0, p_ff[56:32]}; mul_b = INV_TWO_PI_Q64[63:32]; end
         ST_Y:    begin mul_a = {1'b0, f_ff}; mul_b = HALF_PI_Q30; end
         ST_Y2:   begin mul_a = {1'b0, y_ff}; mul_b = {1'b0, y_ff}; end
         ST_TA:   begin mul_a = y2_ff; mul_b = {1'b0, t_ff}; end
         ST_TB:   begin mul_a = x_ff; mul_b = taylor_recip(n_ff); end
         ST_TC:   begin mul_a = q0_ff; mul_b = {24'd0, taylor_div(n_ff)}; end
         ST_SIN:  begin mul_a = {1'b0, y_ff}; mul_b = {1'b0, t_ff}; end
         ST_NUM:  begin mul_a = cmag_ff; mul_b = {1'b0, smag_ff}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // step helpers
   always_comb begin
      dx = {req_target_x[31], req_target_x} - {req_source_x[31], req_source_x};
      dy = {req_target_y[31], req_target_y} - {req_source_y[31], req_source_y};
      dz = {req_target_z[31], req_target_z} - {req_source_z[31], req_source_z};
      ax = dx[32] ? 33'(-dx) : 33'(dx);
      ay = dy[32] ? 33'(-dy) : 33'(dy);
      az = dz[32] ? 33'(-dz) : 33'(dz);
      // half distance, rounded up
      rx = {1'b0, ax} + 34'd1;
      ry = {1'b0, ay} + 34'd1;
      rz = {1'b0, az} + 34'd1;

      sq_bit = 64'd1 << {~cnt_ff[4:0], 1'b0};
      sq_sum = quo_ff + sq_bit;
      sq_ge  = rem_ff >= sq_sum;

      phase = acc_ff[PHASE_SH +: 32];

      div_w  = DIV_W'(r_ff) << EXP_NEG;
      div_r2 = {rem_ff[DIV_W-1:0], dvd_ff[62]};
      div_ge = div_r2 >= {1'b0, div_w};

      td_d   = {24'd0, taylor_div(n_ff)};
      td_rem = x_ff - qd_ff;
      td_q   = (td_rem >= td_d) ? q0_ff + 32'd1 : q0_ff;

      lim       = (chgneg_ff ^ sneg_ff) ? SIGN64 : SIGN64 - 64'd1;
      term_clip = over_ff || (quo_ff > lim);
      qc        = term_clip ? lim : quo_ff;

      add_term = zero_ff ? 64'd0 : term_ff;
      add_sum  = sum_ff + add_term;
      add_ovf  = (sum_ff[63] == add_term[63]) && (add_sum[63] != sum_ff[63]);
   end

   // datapath next values
   always_comb begin
      wave_in     = wave_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      last_in     = last_ff;
      zero_in     = zero_ff;
      sum_in      = sum_ff;
      clip_in     = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      hx_in = hx_ff; hy_in = hy_ff; hz_in = hz_ff;
      cmag_in   = cmag_ff;
      chgneg_in = chgneg_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      r_in      = r_ff;
      p_in      = p_ff;
      f_in      = f_ff;
      sneg_in   = sneg_ff;
      y_in      = y_ff;
      y2_in     = y2_ff;
      t_in      = t_ff;
      x_in      = x_ff;
      q0_in     = q0_ff;
      qd_in     = qd_ff;
      smag_in   = smag_ff;
      dvd_in    = dvd_ff;
      over_in   = over_ff;
      term_in   = term_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_sat_in = rsp_sat_ff;

      if (csr_valid && csr_ready) wave_in = csr_wave_number;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hx_in     = rx[32:1];
               hy_in     = ry[32:1];
               hz_in     = rz[32:1];
               cmag_in   = req_source_charge[31] ? (~req_source_charge + 32'd1)
                                                 : req_source_charge;
               chgneg_in = req_source_charge[31];
               last_in   = req_last_source;
               zero_in   = (dx == '0) && (dy == '0) && (dz == '0);
            end
         end
         ST_SQX: acc_in = {64'd0, prod};
         ST_SQY: acc_in = acc_ff + {64'd0, prod};
         ST_SQZ: begin
            rem_in = acc_ff[63:0] + prod;
            quo_in = '0;
            cnt_in = '0;
         end
         ST_SQRT: begin
            rem_in = sq_ge ? rem_ff - sq_sum : rem_ff;
            quo_in = sq_ge ? (quo_ff >> 1) + sq_bit : quo_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_PH0: begin
            r_in = {quo_ff[31:0], 1'b0};
            p_in = {prod[55:0], 1'b0};
         end
         ST_PH1: acc_in = {64'd0, prod};
         ST_PH2: acc_in = acc_ff + ({64'd0, prod} << 32);
         ST_PH3: acc_in = acc_ff + ({64'd0, prod} << 32);
         ST_PH4: acc_in = acc_ff + ({64'd0, prod} << 64);
         ST_FOLD: begin
            // fold odd quadrants onto the rising quarter wave
            sneg_in = phase[31];
            f_in    = phase[30] ? ONE_Q30[30:0] - {1'b0, phase[29:0]}
                                : {1'b0, phase[29:0]};
         end
         ST_Y: y_in = prod[60:30];
         ST_Y2: begin
            y2_in = prod[61:30];
            t_in  = ONE_Q30[30:0];
            n_in  = '0;
         end
         ST_TA: x_in  = prod[61:30];
         ST_TB: q0_in = prod[63:32];
         ST_TC: qd_in = prod[31:0];
         ST_TD: begin
            // reciprocal estimate is low by at most one
            t_in = 31'(ONE_Q30 - td_q);
            n_in = n_ff + 3'd1;
         end
         ST_SIN: smag_in = prod[60:30];
         ST_NUM: begin
            dvd_in  = prod[62:0];
            rem_in  = '0;
            quo_in  = '0;
            over_in = 1'b0;
            cnt_in  = '0;
         end
         ST_DIV: begin
            rem_in  = 64'(div_ge ? DIV_W'(div_r2 - {1'b0, div_w}) : div_r2[DIV_W-1:0]);
            dvd_in  = {dvd_ff[61:0], 1'b0};
            quo_in  = {quo_ff[62:0], div_ge};
            over_in = over_ff || quo_ff[63];
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ST_TERM: begin
            term_in = (chgneg_ff ^ sneg_ff) ? 64'(-qc) : qc;
            if (term_clip) clip_in = 1'b1;
         end
         ST_ACC: begin
            if (!last_ff) begin
               sum_in  = add_ovf ? (sum_ff[63] ? SIGN64 : SIGN64 - 64'd1) : add_sum;
               clip_in = clip_ff || add_ovf;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = add_ovf ? (sum_ff[63] ? SIGN64 : SIGN64 - 64'd1)
                                      : add_sum;
               rsp_sat_in   = clip_ff || add_ovf;
               sum_in       = '0;
               clip_in      = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wave_ff      <= WAVE_RESET;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         last_ff      <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wave_ff      <= wave_in;
         sum_ff       <= sum_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         last_ff      <= last_in;
         zero_ff      <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      hx_ff      <= hx_in;
      hy_ff      <= hy_in;
      hz_ff      <= hz_in;
      cmag_ff    <= cmag_in;
      chgneg_ff  <= chgneg_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      r_ff       <= r_in;
      p_ff       <= p_in;
      f_ff       <= f_in;
      sneg_ff    <= sneg_in;
      y_ff       <= y_in;
      y2_ff      <= y2_in;
      t_ff       <= t_in;
      x_ff       <= x_in;
      q0_ff      <= q0_in;
      qd_ff      <= qd_in;
      smag_ff    <= smag_in;
      dvd_ff     <= dvd_in;
      over_ff    <= over_in;
      term_ff    <= term_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   // a result only appears out of the accumulate step
   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_ACC))
      else $error("rsp beat raised outside accumulate step");

   // restoring divide keeps its remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff[DIV_W-1:0] < div_w))
      else $error("divide remainder out of range");

   // reciprocal quotient estimate never overshoots
   a_recip_low: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TD) |-> (x_ff >= qd_ff))
      else $error("Taylor quotient estimate too high");

   // a full rsp register is never overwritten before it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_potential_sum)))
      else $error("pending rsp beat lost");

endmodule
